@@ rtl/gme_pkg.sv @@
// gme_pkg: field widths, register reset value and sequencer state codes
// for the Gram matrix engine. No dependencies.

package gme_pkg;

	localparam int SAMPLE_W = 16;
	localparam int PROD_W   = 32;
	localparam int GRAM_W   = 38;
	localparam int CFG_W    = 7;
	localparam int CHAN_W   = 6;
	localparam int POS_W    = 8;

	localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [GRAM_W-1:0]   gram_t;

	localparam int ST_W = 2;
	typedef logic [ST_W-1:0] state_t;

	localparam state_t ST_IDLE  = 2'd0;
	localparam state_t ST_RUN   = 2'd1;
	localparam state_t ST_DRAIN = 2'd2;
	localparam state_t ST_DONE  = 2'd3;

endpackage

@@ rtl/gram_matrix_engine_core.sv @@
// gram_matrix_engine_core: feature sample store and one shared multiply-accumulate
// unit that walks the channels for each Gram entry. Depends on gme_pkg.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+-------------------------------------------
//  in       | in_valid / in_stall          | kind, channel, position_a, position_b, value
//  out      | out_valid / out_stall        | gram_value
//  cfg      | cfg_wr_en (no wait)          | cfg_wr_data = channels_in_use
//
// A write transaction is taken while the core is idle. A read transaction holds the
// core until its result is loaded, n = min(channels_in_use, CHANNELS): one memory
// read of both samples per channel, then a multiply stage and an accumulate stage;
// an out-of-range read or n = 0 goes straight to the done state with a zero result.
// in_stall is high while a read is in progress and while a result waits in the
// sequencer for the output register. Reset clears control and the channel count
// register (64); the sample memory is not cleared.

module gram_matrix_engine_core #(
	parameter int CHANNELS  = 64,
	parameter int POSITIONS = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic [gme_pkg::CFG_W-1:0]  cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       kind,
	input  logic [gme_pkg::CHAN_W-1:0] channel,
	input  logic [gme_pkg::POS_W-1:0]  position_a,
	input  logic [gme_pkg::POS_W-1:0]  position_b,
	input  gme_pkg::sample_t           value,
	output logic                       out_valid,
	input  logic                       out_stall,
	output gme_pkg::gram_t             gram_value
);
	import gme_pkg::*;

	localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PW    = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
	localparam int DEPTH = 1 << (CW + PW);

	state_t             state_q;
	logic [CFG_W-1:0]   cfg_q;
	logic [CFG_W-1:0]   cnt_lim_q;
	logic [CFG_W-1:0]   ch_q;
	logic [PW-1:0]      pa_q;
	logic [PW-1:0]      pb_q;
	gram_t              acc_q;
	logic               out_valid_q;
	gram_t              gram_q;

	logic               vld_s1, last_s1, vld_s2, last_s2;
	sample_t            rd_a_s1, rd_b_s1;
	prod_t              prod_s2;

	sample_t            mem [DEPTH];

	logic               in_acc, wr_ok, rd_ok, last_issue, out_free;
	logic [CFG_W-1:0]   cnt_lim;
	logic [CW+PW-1:0]   wr_addr, rd_addr_a, rd_addr_b;
	gram_t              acc_next;

	assign in_stall   = (state_q != ST_IDLE);
	assign in_acc     = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign gram_value = gram_q;

	assign wr_ok = (32'(channel) < CHANNELS) && (32'(position_a) < POSITIONS);
	assign rd_ok = (32'(position_a) < POSITIONS) && (32'(position_b) < POSITIONS);
	assign cnt_lim = (32'(cfg_q) > CHANNELS) ? CFG_W'(CHANNELS) : cfg_q;

	assign wr_addr    = {CW'(channel), PW'(position_a)};
	assign rd_addr_a  = {CW'(ch_q), pa_q};
	assign rd_addr_b  = {CW'(ch_q), pb_q};
	assign last_issue = (ch_q == cnt_lim_q - 7'd1);
	assign acc_next   = acc_q + GRAM_W'(prod_s2);

	// sample memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (in_acc && !kind && wr_ok) begin
			mem[wr_addr] <= value;
		end
		rd_a_s1 <= mem[rd_addr_a];
		rd_b_s1 <= mem[rd_addr_b];
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(rd_a_s1 * rd_b_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wr_en) begin
			cfg_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			vld_s1  <= (state_q == ST_RUN);
			last_s1 <= (state_q == ST_RUN) && last_issue;
			vld_s2  <= vld_s1;
			last_s2 <= last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pa_q      <= PW'(position_a);
			pb_q      <= PW'(position_b);
			cnt_lim_q <= cnt_lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ch_q    <= '0;
			acc_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && kind) begin
						ch_q  <= '0;
						acc_q <= '0;
						// nothing to sum: result is zero
						if (!rd_ok || cnt_lim == '0) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_RUN;
						end
					end
				end
				ST_RUN: begin
					ch_q <= ch_q + 7'd1;
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
					if (vld_s2) begin
						acc_q <= acc_next;
					end
				end
				ST_DRAIN: begin
					if (vld_s2) begin
						acc_q <= acc_next;
					end
					if (vld_s2 && last_s2) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			gram_q <= acc_q;
		end
	end

`ifndef ASSERT_OFF
	a_last_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && last_s2 |=> state_q == ST_DONE)
		else $error("final product did not close the read transaction");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> ch_q < cnt_lim_q)
		else $error("channel counter ran past the channel count");

	a_pipe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 || vld_s2 |-> state_q != ST_IDLE)
		else $error("input ready while the multiply pipeline is busy");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result loaded outside the done state");
`endif

endmodule

@@ test/tb_gram_matrix_engine_core.sv @@
// tb_gram_matrix_engine_core: self-checking bench for the Gram matrix engine core.
// Sends sample writes and Gram reads with random idling and checks each Gram entry.
// Depends on gme_pkg and gram_matrix_engine_core.

module tb_gram_matrix_engine_core;
	timeunit 1ns;
	timeprecision 1ps;

	import gme_pkg::*;

	localparam int NCH         = 64;
	localparam int NPOS        = 256;
	localparam int ITEMS       = 1850;
	localparam int PHASE_ITEMS = 185;
	localparam int SETTLE      = 80;
	localparam longint LIMIT   = 3000000;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_READ  = 1'b1;

	localparam sample_t S_MIN = 16'sh8000;
	localparam sample_t S_MAX = 16'sh7fff;

	// Predicts Gram entries from its own copy of the sample store and channel count.
	class gram_checker;
		sample_t     samples[NCH][NPOS];
		int unsigned chan_count;
		gram_t       pending_grams[$];
		int          errors;
		int          checked;

		function new();
			chan_count = 32'(CFG_RESET);
			errors     = 0;
			checked    = 0;
		endfunction

		function void set_channels(int unsigned n);
			chan_count = n;
		endfunction

		function gram_t gram_entry(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
			longint      acc;
			int unsigned n;
			acc = 0;
			n = (chan_count > NCH) ? NCH : chan_count;
			if (row >= NPOS || col >= NPOS)
				return '0;
			for (int c = 0; c < n; c++)
				acc += longint'(samples[c][row]) * longint'(samples[c][col]);
			return gram_t'(acc);
		endfunction

		function void note_transaction(logic k, logic [CHAN_W-1:0] ch, logic [POS_W-1:0] pa,
				logic [POS_W-1:0] pb, sample_t v);
			if (k == KIND_WRITE) begin
				if (ch < NCH && pa < NPOS)
					samples[ch][pa] = v;
			end else begin
				pending_grams.push_back(gram_entry(pa, pb));
			end
		endfunction

		task report_mismatch(string msg);
			errors++;
			$display("MISMATCH @%0t: %s", $realtime, msg);
		endtask

		task check_gram(gram_t got);
			gram_t want;
			if (pending_grams.size() == 0) begin
				report_mismatch($sformatf("result %0d with nothing outstanding", got));
				return;
			end
			want = pending_grams.pop_front();
			checked++;
			if (got !== want)
				report_mismatch($sformatf("gram_value %0d, expected %0d", got, want));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	logic [CFG_W-1:0]    cfg_wr_data;
	logic                in_valid;
	logic                in_stall;
	logic                kind;
	logic [CHAN_W-1:0]   channel;
	logic [POS_W-1:0]    position_a;
	logic [POS_W-1:0]    position_b;
	sample_t             value;
	logic                out_valid;
	logic                out_stall;
	gram_t               gram_value;

	gram_checker board = new();

	longint      cycles = 0;
	int unsigned n_writes = 0;
	int unsigned n_reads = 0;
	int unsigned n_settings = 0;
	bit          pressure_req = 1'b0;
	bit          rx_holding = 1'b0;
	bit          loaded[NCH][NPOS];
	int          ready_pos[$];

	gram_matrix_engine_core #(
		.CHANNELS (NCH),
		.POSITIONS(NPOS)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.channel    (channel),
		.position_a (position_a),
		.position_b (position_b),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.gram_value (gram_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Result side: random stall pattern plus one long hold-off on request.
	initial begin
		int run_left;
		int hold_left;
		int r;
		bit pressure_done;
		bit stall_now;
		run_left      = 0;
		hold_left     = 0;
		pressure_done = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall)
				board.check_gram(gram_value);
			if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				rx_holding    = 1'b1;
				hold_left     = 600;
				stall_now     = 1'b1;
			end else if (hold_left > 0) begin
				hold_left--;
				stall_now = 1'b1;
			end else begin
				rx_holding = 1'b0;
				if (run_left > 0) begin
					run_left--;
					stall_now = 1'b0;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 50) begin
						run_left  = $urandom_range(0, 12);
						stall_now = 1'b0;
					end else if (r < 55) begin
						run_left  = $urandom_range(100, 300);
						stall_now = 1'b0;
					end else if (r < 92) begin
						hold_left = $urandom_range(0, 2);
						stall_now = 1'b1;
					end else begin
						hold_left = $urandom_range(15, 90);
						stall_now = 1'b1;
					end
				end
			end
			out_stall <= stall_now;
		end
	end

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 7))
			0: return S_MIN;
			1: return S_MAX;
			2: return '0;
			3: return '1;
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Positions whose leading n channels are all written; only these may be read.
	function automatic void refresh_ready(int n);
		bit ok;
		ready_pos.delete();
		for (int p = 0; p < NPOS; p++) begin
			ok = 1'b1;
			for (int c = 0; c < n; c++)
				if (!loaded[c][p])
					ok = 1'b0;
			if (ok)
				ready_pos.push_back(p);
		end
	endfunction

	// Returns right after the edge at which the transaction was taken.
	task automatic send_txn(logic k, logic [CHAN_W-1:0] ch, logic [POS_W-1:0] pa,
			logic [POS_W-1:0] pb, sample_t v);
		int gap;
		int r;
		r = $urandom_range(0, 99);
		if (rx_holding || r < 50)
			gap = 0;
		else if (r < 90)
			gap = $urandom_range(1, 3);
		else if (r < 98)
			gap = $urandom_range(4, 12);
		else
			gap = $urandom_range(30, 100);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		channel    <= ch;
		position_a <= pa;
		position_b <= pb;
		value      <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_transaction(k, ch, pa, pb, v);
		if (k == KIND_READ)
			n_reads++;
		else
			n_writes++;
	endtask

	task automatic write_sample(int ch, int p, sample_t v);
		loaded[ch][p] = 1'b1;
		send_txn(KIND_WRITE, CHAN_W'(ch), POS_W'(p), POS_W'($urandom), v);
	endtask

	task automatic read_gram(int a, int b);
		send_txn(KIND_READ, CHAN_W'($urandom), POS_W'(a), POS_W'(b), sample_t'($urandom));
	endtask

	task automatic load_column(int p, int n);
		for (int c = 0; c < n; c++)
			write_sample(c, p, pick_sample());
		refresh_ready(n);
	endtask

	// Register write only once the core has drained.
	task automatic set_channels(int unsigned n);
		in_valid <= 1'b0;
		while (board.pending_grams.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(n);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.set_channels(n);
		n_settings++;
	endtask

	initial begin
		int unsigned cfg_plan[10] = '{127, 1, 64, 7, 0, 33, 64, 100, 2, 64};
		int unsigned cnt;
		int          eff;
		int          phase;
		int          start_items;
		int          start_reads;
		int          r;
		int          a;
		int          b;

		arst_n      <= 1'b0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		in_valid    <= 1'b0;
		kind        <= KIND_WRITE;
		channel     <= '0;
		position_a  <= '0;
		position_b  <= '0;
		value       <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: sample extremes, edge positions, top channel, overwrite, zero channels.
		set_channels(2);
		write_sample(0, 0, S_MIN);
		write_sample(1, 0, S_MIN);
		write_sample(0, NPOS - 1, S_MIN);
		write_sample(1, NPOS - 1, S_MAX);
		write_sample(0, 1, S_MAX);
		write_sample(1, 1, S_MAX);
		write_sample(0, 2, '0);
		write_sample(1, 2, '1);
		write_sample(NCH - 1, 128, 16'sh5a5a);
		read_gram(0, 0);
		read_gram(0, NPOS - 1);
		read_gram(NPOS - 1, NPOS - 1);
		read_gram(NPOS - 1, 0);
		read_gram(1, 1);
		read_gram(0, 1);
		read_gram(2, 2);
		read_gram(2, 0);
		write_sample(0, 2, S_MAX);
		read_gram(2, 1);
		set_channels(0);
		read_gram(0, NPOS - 1);
		read_gram(200, 17);

		// Random phases, one channel count each.
		phase = 0;
		while (n_writes + n_reads < ITEMS) begin
			cnt = (phase < 10) ? cfg_plan[phase] : $urandom_range(0, 127);
			set_channels(cnt);
			eff = (cnt > NCH) ? NCH : cnt;
			refresh_ready(eff);
			if (phase == 2)
				pressure_req = 1'b1;
			start_items = n_writes + n_reads;
			start_reads = n_reads;
			while ((n_writes + n_reads - start_items < PHASE_ITEMS || n_reads - start_reads < 20)
					&& n_writes + n_reads < ITEMS + 200) begin
				r = $urandom_range(0, 99);
				if (eff > 0 && (ready_pos.size() < 3 || r < (eff > 16 ? 1 : 8))) begin
					load_column($urandom_range(0, NPOS - 1), eff);
				end else if (r < 80) begin
					a = ready_pos[$urandom_range(0, ready_pos.size() - 1)];
					b = ($urandom_range(0, 9) == 0) ? a :
						ready_pos[$urandom_range(0, ready_pos.size() - 1)];
					read_gram(a, b);
				end else begin
					write_sample($urandom_range(0, NCH - 1), $urandom_range(0, NPOS - 1),
						pick_sample());
				end
			end
			phase++;
		end

		in_valid <= 1'b0;
		while (board.pending_grams.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("Ran %0d transactions: %0d sample writes, %0d Gram reads (%0d checked)",
			n_writes + n_reads, n_writes, n_reads, board.checked);
		$display("Channel count written %0d times, zero and over-range included; %0d mismatches",
			n_settings, board.errors);
		if (board.errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
